@@ hw/rtl/spfc_pkg.sv @@
// Shared types, constants and register codes of the scanout pixel format converter.
package spfc_pkg;

    // Screen extent and the coordinate widths that follow from it.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field widths.
    localparam int PIX_W   = 32;
    localparam int ADDR_W  = 48;
    localparam int PITCH_W = 16;
    localparam int SIZE_W  = 2;
    localparam int CFG_W   = 48;
    localparam int IDX_W   = 2;

    // Packed beat widths, rounded up to whole bytes.
    localparam int IN_BITS  = PIX_W + COL_W + ROW_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = ADDR_W + PIX_W + SIZE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Luma weights and dither thresholds.
    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd150;
    localparam logic [7:0] LUMA_B = 8'd29;
    localparam logic [7:0] THR_EVEN_EVEN = 8'd0;
    localparam logic [7:0] THR_EVEN_ODD  = 8'd128;
    localparam logic [7:0] THR_ODD_EVEN  = 8'd192;
    localparam logic [7:0] THR_ODD_ODD   = 8'd64;
    localparam logic [7:0] SAT_MAX       = 8'd255;

    localparam logic [PIX_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;
    localparam logic [PIX_W-1:0] OPAQUE_WHITE = 32'hFFFF_FFFF;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 16'd8192;

    // Output format codes.
    typedef enum logic [1:0] {
        FMT_DISPLAY32 = 2'd0,
        FMT_RGB565    = 2'd1,
        FMT_8BPP      = 2'd2,
        FMT_CAPTURE32 = 2'd3
    } fmt_t;

    // Color mode codes.
    typedef enum logic [1:0] {
        MODE_COLOR  = 2'd0,
        MODE_GRAY   = 2'd1,
        MODE_MONO   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    // Register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_OUT_FORMAT = 2'd0,
        REG_TONE_MODE  = 2'd1,
        REG_DEST_BASE  = 2'd2,
        REG_ROW_PITCH  = 2'd3
    } reg_idx_t;

    // Size codes.
    localparam logic [SIZE_W-1:0] SIZE_ONE  = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_TWO  = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_FOUR = 2'd2;

    // Configuration seen by the datapath.
    typedef struct packed {
        fmt_t                 out_format;
        mode_t                tone_mode;
        logic [ADDR_W-1:0]    dest_base;
        logic [PITCH_W-1:0]   row_pitch;
    } cfg_t;

endpackage

@@ hw/rtl/spfc_convert.sv @@
// Pixel conversion: RGB565, luma, dithered mono, RGB332 and capture expansion.
module spfc_convert
    import spfc_pkg::*;
(
    input  cfg_t             cfg,
    input  logic [PIX_W-1:0] pixel_in,
    input  logic             col_lsb,
    input  logic             row_lsb,
    output logic [PIX_W-1:0] pixel_out,
    output logic [SIZE_W-1:0] size_code
);

    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] luma_sum;
    logic [7:0]  luma;
    logic [7:0]  mono_level;
    logic [7:0]  threshold;
    logic        mono_on;

    assign red   = pixel_in[23:16];
    assign green = pixel_in[15:8];
    assign blue  = pixel_in[7:0];

    // Weighted sum never exceeds 255 * 256, so 16 bits hold it.
    assign luma_sum = 16'(red) * 16'(LUMA_R) + 16'(green) * 16'(LUMA_G)
                    + 16'(blue) * 16'(LUMA_B);
    assign luma     = luma_sum[15:8];

    // Doubled luma saturates at full scale.
    assign mono_level = luma[7] ? SAT_MAX : {luma[6:0], 1'b0};

    // 2x2 Bayer threshold picked by the low coordinate bits.
    always_comb
    begin
        case ({row_lsb, col_lsb})
            2'b00:   threshold = THR_EVEN_EVEN;
            2'b01:   threshold = THR_EVEN_ODD;
            2'b10:   threshold = THR_ODD_EVEN;
            default: threshold = THR_ODD_ODD;
        endcase
    end

    assign mono_on = mono_level > threshold;

    // Format and mode selection.
    always_comb
    begin
        case (cfg.out_format)
            FMT_RGB565:
            begin
                size_code = SIZE_TWO;
                pixel_out = {16'd0, red[7:3], green[7:2], blue[7:3]};
            end
            FMT_8BPP:
            begin
                size_code = SIZE_ONE;
                case (cfg.tone_mode)
                    MODE_GRAY: pixel_out = {24'd0, luma};
                    MODE_MONO: pixel_out = {24'd0, mono_on ? SAT_MAX : 8'd0};
                    default:   pixel_out = {24'd0, red[7:5], green[7:5], blue[7:6]};
                endcase
            end
            FMT_CAPTURE32:
            begin
                size_code = SIZE_FOUR;
                case (cfg.tone_mode)
                    MODE_GRAY: pixel_out = OPAQUE_BLACK | {8'd0, luma, luma, luma};
                    MODE_MONO: pixel_out = mono_on ? OPAQUE_WHITE : OPAQUE_BLACK;
                    default:   pixel_out = pixel_in;
                endcase
            end
            default:
            begin
                size_code = SIZE_FOUR;
                pixel_out = pixel_in;
            end
        endcase
    end

endmodule

@@ hw/rtl/spfc_addr.sv @@
// Destination address: base plus row times pitch plus column times pixel bytes.
module spfc_addr
    import spfc_pkg::*;
(
    input  cfg_t              cfg,
    input  logic [COL_W-1:0]  col,
    input  logic [ROW_W-1:0]  row,
    output logic [ADDR_W-1:0] dest_addr
);

    localparam int PROD_W = ROW_W + PITCH_W;
    localparam int XOFF_W = COL_W + 2;

    logic [PROD_W-1:0] row_offset;
    logic [XOFF_W-1:0] col_offset;

    assign row_offset = PROD_W'(row) * PROD_W'(cfg.row_pitch);

    // Column offset scales by the bytes per pixel of the format.
    always_comb
    begin
        case (cfg.out_format)
            FMT_RGB565: col_offset = {1'b0, col, 1'b0};
            FMT_8BPP:   col_offset = {2'b00, col};
            default:    col_offset = {col, 2'b00};
        endcase
    end

    // The sum wraps at the address width.
    assign dest_addr = cfg.dest_base + ADDR_W'(row_offset) + ADDR_W'(col_offset);

endmodule

@@ hw/rtl/scanout_pixel_format_converter_top.sv @@
// Top level: configuration registers, input and result registers, conversion datapath.
// A beat accepted into the input register is converted and moves into the result register
// once that register is free; it is presented on the output from the result register.
// Throughput: one beat per cycle unless m_axis_tready stalls; conversion and the address
// sum sit between the input and result registers, with one 11x16 multiplier in that path.
// Reset (rst_n low, asynchronous) empties both stages and returns the registers to
// format 0, color mode 0, base 0 and pitch 8192.
module scanout_pixel_format_converter_top
    import spfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration write port.
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    // Input stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // Fields from bit 0: pixel_in[31:0], col[42:32], row[53:43], zero fill.
    input  logic [IN_W-1:0]   s_axis_tdata,
    // Output stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // Fields from bit 0: dest_addr[47:0], pixel_out[79:48], size_code[81:80], zero fill.
    output logic [OUT_W-1:0]  m_axis_tdata
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              out_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg;

    logic              out_free;
    logic              advance;
    logic [PIX_W-1:0]  conv_pixel;
    logic [SIZE_W-1:0] conv_size;
    logic [ADDR_W-1:0] conv_addr;

    // Configuration registers; unknown indexes cannot occur in two bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_format <= FMT_DISPLAY32;
            cfg_reg.tone_mode  <= MODE_COLOR;
            cfg_reg.dest_base  <= '0;
            cfg_reg.row_pitch  <= PITCH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OUT_FORMAT: cfg_reg.out_format <= fmt_t'(cfg_data[1:0]);
                REG_TONE_MODE:  cfg_reg.tone_mode  <= mode_t'(cfg_data[1:0]);
                REG_DEST_BASE:  cfg_reg.dest_base  <= cfg_data[ADDR_W-1:0];
                REG_ROW_PITCH:  cfg_reg.row_pitch  <= cfg_data[PITCH_W-1:0];
                default:        cfg_reg.row_pitch  <= cfg_reg.row_pitch;
            endcase
        end
    end

    // Handshake: the input stage moves on whenever the result register can take it.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // Input stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            pix_reg <= s_axis_tdata[PIX_W-1:0];
            col_reg <= s_axis_tdata[PIX_W+COL_W-1:PIX_W];
            row_reg <= s_axis_tdata[PIX_W+COL_W+ROW_W-1:PIX_W+COL_W];
        end
    end

    // Conversion datapath.
    spfc_convert u_convert
    (
        .cfg       (cfg_reg),
        .pixel_in  (pix_reg),
        .col_lsb   (col_reg[0]),
        .row_lsb   (row_reg[0]),
        .pixel_out (conv_pixel),
        .size_code (conv_size)
    );

    spfc_addr u_addr
    (
        .cfg       (cfg_reg),
        .col       (col_reg),
        .row       (row_reg),
        .dest_addr (conv_addr)
    );

    // Result stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {conv_size, conv_pixel, conv_addr};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

endmodule

@@ tb/sv/tb_scanout_pixel_format_converter_top.sv @@
// Self-checking testbench for the scanout pixel format converter top level.
`timescale 1ns / 1ps

module tb_scanout_pixel_format_converter_top
    import spfc_pkg::*;
();

    // Source pixel with its screen coordinates.
    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } pixel_beat_t;

    // Destination write that a pixel turns into.
    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pixel;
        logic [SIZE_W-1:0] size;
    } pixel_write_t;

    localparam int HOLD_CYCLES    = 300;
    localparam int SEG_PIXELS     = 64;
    localparam int MAX_ERR_LINES  = 20;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // Fields from bit 0: pixel_in, col, row, zero fill.
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // Fields from bit 0: dest_addr, pixel_out, size_code, zero fill.
    logic [OUT_W-1:0]  m_axis_tdata;

    // Local copy of the register file.
    fmt_t              cur_format = FMT_DISPLAY32;
    mode_t             cur_mode = MODE_COLOR;
    logic [ADDR_W-1:0] cur_base = '0;
    logic [PITCH_W-1:0] cur_pitch = PITCH_RESET;

    pixel_beat_t  pending_pixels[$];
    pixel_write_t expected_writes[$];
    pixel_beat_t  beat_on_bus;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    longint      rx_cycle = 0;
    longint      hold_from = 64'h7FFF_FFFF_FFFF_0000;
    int          mismatch_count = 0;
    int          writes_checked = 0;

    scanout_pixel_format_converter_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Expected destination write for one pixel under the current registers.
    function automatic pixel_write_t convert_pixel(pixel_beat_t b);
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        int unsigned  weighted;
        logic [7:0]   luma;
        logic [7:0]   doubled;
        logic [7:0]   threshold;
        logic         lit;
        logic [63:0]  bytes;
        logic [63:0]  sum;
        pixel_write_t w;
        red   = b.pixel[23:16];
        green = b.pixel[15:8];
        blue  = b.pixel[7:0];
        weighted = 77 * red + 150 * green + 29 * blue;
        luma = weighted[15:8];
        doubled = luma[7] ? 8'd255 : {luma[6:0], 1'b0};
        // Two by two ordered dither: even rows 0 and 128, odd rows 192 and 64.
        case ({b.row[0], b.col[0]})
            2'b00: threshold = 8'd0;
            2'b01: threshold = 8'd128;
            2'b10: threshold = 8'd192;
            default: threshold = 8'd64;
        endcase
        lit = doubled > threshold;
        case (cur_format)
            FMT_RGB565:
            begin
                bytes = 64'd2;
                w.size = SIZE_TWO;
                w.pixel = {16'd0, red[7:3], green[7:2], blue[7:3]};
            end
            FMT_8BPP:
            begin
                bytes = 64'd1;
                w.size = SIZE_ONE;
                if (cur_mode == MODE_GRAY)
                    w.pixel = {24'd0, luma};
                else if (cur_mode == MODE_MONO)
                    w.pixel = lit ? 32'd255 : 32'd0;
                else
                    w.pixel = {24'd0, red[7:5], green[7:5], blue[7:6]};
            end
            FMT_CAPTURE32:
            begin
                bytes = 64'd4;
                w.size = SIZE_FOUR;
                if (cur_mode == MODE_GRAY)
                    w.pixel = {8'hFF, luma, luma, luma};
                else if (cur_mode == MODE_MONO)
                    w.pixel = lit ? 32'hFFFF_FFFF : 32'hFF00_0000;
                else
                    w.pixel = b.pixel;
            end
            default:
            begin
                bytes = 64'd4;
                w.size = SIZE_FOUR;
                w.pixel = b.pixel;
            end
        endcase
        sum = 64'(cur_base) + 64'(b.row) * 64'(cur_pitch) + 64'(b.col) * bytes;
        w.addr = sum[ADDR_W-1:0];
        return w;
    endfunction

    // Prints one mismatch line (up to a cap) and counts it.
    task automatic report_mismatch(string what);
        if (mismatch_count < MAX_ERR_LINES)
            $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Input driver: offers pending pixels and records what each accepted one should give.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_writes.push_back(convert_pixel(beat_on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    beat_on_bus = pending_pixels.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= IN_W'({beat_on_bus.row, beat_on_bus.col,
                                           beat_on_bus.pixel});
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random stalls plus one long hold-off window counted here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle = rx_cycle + 1;
            if (rx_cycle >= hold_from && rx_cycle < hold_from + HOLD_CYCLES)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output monitor: compares each accepted beat with the oldest expected write.
    always @(posedge clk)
    begin
        pixel_write_t got;
        pixel_write_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.addr  = m_axis_tdata[ADDR_W-1:0];
            got.pixel = m_axis_tdata[ADDR_W +: PIX_W];
            got.size  = m_axis_tdata[ADDR_W+PIX_W +: SIZE_W];
            if (expected_writes.size() == 0)
            begin
                report_mismatch("output beat with no pixel outstanding");
            end
            else
            begin
                want = expected_writes.pop_front();
                if (got.addr !== want.addr)
                    report_mismatch($sformatf("dest_addr %h, expected %h",
                                              got.addr, want.addr));
                if (got.pixel !== want.pixel)
                    report_mismatch($sformatf("pixel_out %h, expected %h",
                                              got.pixel, want.pixel));
                if (got.size !== want.size)
                    report_mismatch($sformatf("size_code %0d, expected %0d",
                                              got.size, want.size));
            end
            writes_checked++;
        end
    end

    // Waits until every queued pixel has been sent and its write has come back.
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_writes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write; set_config puts random bits above the field for format, mode and pitch.
    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Drains the block, then writes all four registers and updates the local copy.
    task automatic set_config(fmt_t fmt, mode_t mode, logic [ADDR_W-1:0] base,
                              logic [PITCH_W-1:0] pitch);
        logic [63:0] junk;
        wait_drained();
        junk = {$urandom(), $urandom()};
        write_reg(REG_OUT_FORMAT, {junk[CFG_W-1:2], fmt});
        write_reg(REG_TONE_MODE, {junk[CFG_W-1:4], 2'b00, mode});
        write_reg(REG_DEST_BASE, base);
        write_reg(REG_ROW_PITCH, {junk[CFG_W-1:PITCH_W], pitch});
        cur_format = fmt;
        cur_mode = mode;
        cur_base = base;
        cur_pitch = pitch;
    endtask

    task automatic queue_pixel(logic [PIX_W-1:0] pixel, int col, int row);
        pixel_beat_t b;
        b.pixel = pixel;
        b.col = col[COL_W-1:0];
        b.row = row[ROW_W-1:0];
        pending_pixels.push_back(b);
    endtask

    // Random pixel; a third are gray so that luma lands near every dither threshold.
    task automatic queue_random_pixel();
        logic [7:0]  gray;
        logic [7:0]  alpha;
        logic [31:0] pixel;
        int          col;
        int          row;
        gray = 8'($urandom_range(255));
        alpha = 8'($urandom_range(255));
        pixel = ($urandom_range(2) == 0) ? {alpha, gray, gray, gray} : $urandom();
        col = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 2047 : 0) : $urandom_range(2047);
        row = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 2047 : 0) : $urandom_range(2047);
        queue_pixel(pixel, col, row);
    endtask

    // Stimulus and end of run.
    initial
    begin
        logic [63:0] wide;
        logic [ADDR_W-1:0] base;
        logic [PITCH_W-1:0] pitch;
        int k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers straight out of reset.
        queue_pixel(32'hFFFF_FFFF, 2047, 2047);
        queue_pixel(32'h0000_0000, 0, 0);
        set_config(FMT_RGB565, MODE_MONO, 48'h0000_1000_0000, 16'd4096);
        queue_pixel(32'h1234_5678, 5, 3);
        queue_pixel(32'hFFFF_FFFF, 2047, 1);
        set_config(FMT_8BPP, MODE_COLOR, 48'd0, 16'd0);
        queue_pixel(32'h00FF_E0C0, 7, 9);
        queue_pixel(32'hAA1F_3F3F, 2047, 2047);
        set_config(FMT_8BPP, MODE_GRAY, 48'd64, 16'd2048);
        queue_pixel(32'h00FF_FFFF, 1, 1);
        queue_pixel(32'hFF01_0101, 0, 2);
        // Mono dither: each threshold hit exactly, thresholds 0, 128 and 192 just exceeded, plus saturation.
        set_config(FMT_8BPP, MODE_MONO, 48'd0, 16'd640);
        queue_pixel(32'h0000_0000, 0, 0);
        queue_pixel(32'h0001_0101, 0, 0);
        queue_pixel(32'h0040_4040, 1, 0);
        queue_pixel(32'h0041_4141, 1, 0);
        queue_pixel(32'h0060_6060, 0, 1);
        queue_pixel(32'h0061_6161, 0, 1);
        queue_pixel(32'h0020_2020, 1, 1);
        queue_pixel(32'h0080_8080, 1, 1);
        set_config(FMT_CAPTURE32, MODE_GRAY, 48'h8000_0000_0000, 16'd1);
        queue_pixel(32'hAB80_8080, 3, 4);
        set_config(FMT_CAPTURE32, MODE_MONO, 48'd4, 16'd8);
        queue_pixel(32'h1260_6060, 0, 1);
        queue_pixel(32'h34FF_FFFF, 0, 1);
        // The unused color mode falls back to standard color.
        set_config(FMT_CAPTURE32, MODE_UNUSED, 48'd0, 16'd100);
        queue_pixel(32'h89AB_CDEF, 10, 20);
        set_config(FMT_8BPP, MODE_UNUSED, 48'd0, 16'd100);
        queue_pixel(32'h89AB_CDEF, 11, 21);
        // Address sum wraps past the top of the address space.
        set_config(FMT_DISPLAY32, MODE_GRAY, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        queue_pixel(32'h5A5A_A5A5, 2047, 2047);

        // Random part: four flow-control phases, every format and mode pair.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                k = phase * 4 + seg;
                wide = {$urandom(), $urandom()};
                case ($urandom_range(3))
                    0: base = '0;
                    1: base = '1;
                    default: base = wide[ADDR_W-1:0];
                endcase
                case ($urandom_range(3))
                    0: pitch = '0;
                    1: pitch = '1;
                    default: pitch = 16'($urandom());
                endcase
                set_config(fmt_t'(k[1:0]), mode_t'(k[3:2]), base, pitch);
                // Long output hold-off while the input keeps offering pixels.
                if (phase == 0 && seg == 0)
                    hold_from = rx_cycle + 3;
                repeat (SEG_PIXELS) queue_random_pixel();
            end
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (expected_writes.size() != 0)
            report_mismatch("pixels left without an output beat");
        $display("Checked %0d destination writes over all 16 format and color mode pairs,",
                 writes_checked);
        $display("base and pitch extremes, four flow-control phases and a long output stall.");
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("ERROR: run timed out");
        $display("FAIL");
        $finish;
    end

endmodule
